// File: hdl/spq_pkg.sv
package spq_pkg;

  localparam int ValW = 32;
  localparam int CountW = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic pop;
  } spq_cmd_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell import spq_pkg::*; (
  input  logic     clk,
  input  spq_cmd_t cmd,
  input  val_t     value,
  input  logic     found,
  input  logic     occ,
  input  logic     at_fill,
  input  val_t     left_entry,
  input  logic     left_mark,
  input  val_t     right_entry,
  output val_t     entry,
  output logic     mark,
  output logic     eq
);

  logic gt;
  logic ge;
  val_t entry_next;

  assign gt   = occ && (entry > value);
  assign ge   = occ && (entry >= value);
  assign eq   = occ && (entry == value);
  assign mark = gt || at_fill;

  always_comb begin
    entry_next = entry;
    if (cmd.ins && mark) begin
      entry_next = left_mark ? left_entry : value;
    end else if (cmd.pop || (cmd.rem && found && ge)) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue: keeps up to DEPTH signed 32-bit values in ascending
// order in a row of cells, each holding one entry and trading it with its
// neighbors. Insert broadcasts the value to every cell, the cells at and
// above the insert point shift up by one, and equal values keep arrival order.
// Remove deletes the first equal entry and pop takes the smallest, both by
// shifting the upper cells down by one. Every request returns one result beat
// with status, popped value, count and an empty flag; a new request is taken
// every cycle while the result register is free or being drained. The cycle
// time is set by the value broadcast and compare across all DEPTH cells plus
// the found reduction for remove.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  val_t              value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output val_t              popped,
  output logic [CountW-1:0] count,
  output logic              is_empty
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;
  logic [FW+CountW-1:0] fill_ext;
  logic                 accept;
  logic                 full;
  logic                 found;
  logic [1:0]           status_next;
  val_t                 popped_next;
  spq_cmd_t             cmd;
  val_t                 ent  [DEPTH];
  logic [DEPTH-1:0]     mark;
  logic [DEPTH-1:0]     eq;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (fill == FW'(DEPTH));
  assign found    = |eq;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .value       (value),
        .found       (found),
        .occ         (fill > FW'(i)),
        .at_fill     (fill == FW'(i)),
        .left_entry  ((i == 0) ? value : ent[(i == 0) ? 0 : i-1]),
        .left_mark   ((i == 0) ? 1'b0 : mark[(i == 0) ? 0 : i-1]),
        .right_entry (ent[(i == DEPTH-1) ? i : i+1]),
        .entry       (ent[i]),
        .mark        (mark[i]),
        .eq          (eq[i])
      );
    end
  endgenerate

  always_comb begin
    cmd         = '0;
    status_next = ST_OK;
    popped_next = '0;
    fill_next   = fill;
    if (accept) begin
      unique case (mode)
        MODE_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.ins   = 1'b1;
            fill_next = fill + FW'(1);
          end
        end
        MODE_REMOVE: begin
          if (fill == '0) begin
            status_next = ST_EMPTY;
          end else if (!found) begin
            status_next = ST_MISSING;
          end else begin
            cmd.rem   = 1'b1;
            fill_next = fill - FW'(1);
          end
        end
        MODE_POP: begin
          if (fill == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cmd.pop     = 1'b1;
            popped_next = ent[0];
            fill_next   = fill - FW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign fill_ext = {{CountW{1'b0}}, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      popped   <= popped_next;
      count    <= fill_ext[CountW-1:0];
      is_empty <= (fill_next == '0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill beyond depth");

  a_accept_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request gave no result beat");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_INSERT && !full) |=> fill == $past(fill) + FW'(1))
    else $error("insert did not grow fill");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_INSERT && full) |=> $stable(fill))
    else $error("dropped insert changed fill");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (fill == '0 && !out_valid))
    else $error("reset left queue state");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int QDEPTH = 64;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    val_t              popped;
    logic [CountW-1:0] count;
    logic              is_empty;
  } spq_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_pattern_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        mode = MODE_INSERT;
  val_t              value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  val_t              popped;
  logic [CountW-1:0] count;
  logic              is_empty;

  val_t        sorted_vals[$];
  spq_result_t pending_results[$];
  spq_result_t exp_res;
  int          mismatches = 0;
  int          sent_count = 0;
  int          burst_left = 1;
  bit          gaps_on = 1'b1;
  rx_pattern_t rx_pattern = RX_OPEN;
  logic [15:0] rx_tick = '0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .popped(popped),
    .count(count),
    .is_empty(is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3ms;
    $display("sorted_priority_queue: mismatch");
    $finish;
  end

  // ascending store, equal values kept in arrival order
  function automatic spq_result_t apply_request(logic [1:0] m, val_t v);
    spq_result_t r;
    int k;
    bit hit;
    r.status = ST_OK;
    r.popped = '0;
    hit = 1'b0;
    case (m)
      MODE_INSERT: begin
        if (sorted_vals.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          k = sorted_vals.size();
          while (k > 0 && sorted_vals[k-1] > v) k--;
          sorted_vals.insert(k, v);
        end
      end
      MODE_REMOVE: begin
        if (sorted_vals.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_MISSING;
          for (k = 0; k < sorted_vals.size() && !hit; k++) begin
            if (sorted_vals[k] == v) begin
              sorted_vals.delete(k);
              r.status = ST_OK;
              hit = 1'b1;
            end
          end
        end
      end
      MODE_POP: begin
        if (sorted_vals.size() == 0) r.status = ST_EMPTY;
        else r.popped = sorted_vals.pop_front();
      end
      default: ;
    endcase
    r.count = CountW'(sorted_vals.size());
    r.is_empty = (sorted_vals.size() == 0);
    return r;
  endfunction

  function automatic val_t pick_value(bit from_store);
    int sel;
    sel = $urandom_range(0, 9);
    if (from_store && sorted_vals.size() != 0 && sel < 6)
      return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    if (sel < 4) return val_t'(int'($urandom_range(0, 16)) - 8);
    if (sel < 8) return val_t'($urandom);
    case ($urandom_range(0, 3))
      0: return val_t'(32'h7fff_ffff);
      1: return val_t'(32'h8000_0000);
      2: return val_t'(32'hffff_ffff);
      default: return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[7:0] == 8'd0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_tick % 5) == 0;
      default:   out_ready <= rx_tick[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_results.push_back(apply_request(mode, value));
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: status %0d popped %0d count %0d is_empty %0d",
                 $time, status, popped, count, is_empty);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status) begin
          $display("%0t status: expected %0d, got %0d", $time, exp_res.status, status);
          mismatches++;
        end
        if (popped !== exp_res.popped) begin
          $display("%0t popped: expected %0d, got %0d", $time, exp_res.popped, popped);
          mismatches++;
        end
        if (count !== exp_res.count) begin
          $display("%0t count: expected %0d, got %0d", $time, exp_res.count, count);
          mismatches++;
        end
        if (is_empty !== exp_res.is_empty) begin
          $display("%0t is_empty: expected %0d, got %0d", $time, exp_res.is_empty,
                   is_empty);
          mismatches++;
        end
      end
    end
  end

  task automatic send_req(input logic [1:0] m, input val_t v);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_requests();
    send_req(MODE_POP, val_t'(32'h1234_5678));
    send_req(MODE_REMOVE, val_t'(5));
    send_req(MODE_RESERVED, '0);
    send_req(MODE_INSERT, val_t'(-3));
    send_req(MODE_POP, '0);
  endtask

  task automatic test_value_extremes();
    send_req(MODE_INSERT, val_t'(32'h7fff_ffff));
    send_req(MODE_INSERT, val_t'(32'h8000_0000));
    send_req(MODE_INSERT, '0);
    send_req(MODE_INSERT, val_t'(-1));
    send_req(MODE_INSERT, val_t'(1));
    send_req(MODE_INSERT, val_t'(32'h8000_0000));
    send_req(MODE_INSERT, val_t'(32'h7fff_ffff));
    send_req(MODE_REMOVE, val_t'(32'h1234_5678));
    send_req(MODE_REMOVE, val_t'(-1));
    send_req(MODE_REMOVE, val_t'(32'h8000_0000));
    send_req(MODE_RESERVED, val_t'(32'hffff_ffff));
    repeat (6) send_req(MODE_POP, val_t'(32'haaaa_5555));
  endtask

  task automatic test_fill_and_overflow();
    int room;
    int k;
    wait_all_results();
    room = QDEPTH - sorted_vals.size();
    for (k = 0; k < room + 3; k++) send_req(MODE_INSERT, pick_value(1'b0));
    send_req(MODE_RESERVED, pick_value(1'b0));
    wait_all_results();
    for (k = 0; k < 10; k++) send_req(MODE_REMOVE, pick_value(1'b1));
    for (k = 0; k < QDEPTH; k++) send_req(MODE_POP, val_t'($urandom));
  endtask

  task automatic test_mixed_traffic(input int target);
    mix_t profile;
    int run_len;
    int r;
    int ins_lim;
    int rem_lim;
    int pop_lim;
    logic [1:0] op;
    while (sent_count < target) begin
      profile = mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(20, 120);
      gaps_on = ($urandom_range(0, 3) != 0);
      case (profile)
        MIX_FILL: begin
          ins_lim = 75; rem_lim = 87; pop_lim = 98;
        end
        MIX_DRAIN: begin
          ins_lim = 20; rem_lim = 50; pop_lim = 98;
        end
        default: begin
          ins_lim = 40; rem_lim = 70; pop_lim = 98;
        end
      endcase
      repeat (run_len) begin
        r = $urandom_range(0, 99);
        op = (r < ins_lim) ? MODE_INSERT :
             (r < rem_lim) ? MODE_REMOVE :
             (r < pop_lim) ? MODE_POP : MODE_RESERVED;
        send_req(op, pick_value(op == MODE_REMOVE));
      end
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_requests();
    test_value_extremes();
    wait_all_results();
    test_fill_and_overflow();
    test_mixed_traffic(1620);
    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/tb_top.sv
